// ----- rtl/core/bud_pkg.sv -----
// Shared types, constants and helpers of the buddy allocator.
package bud_pkg;

    localparam int TREE_LEVELS = 11;
    localparam int NODE_COUNT  = (1 << TREE_LEVELS) - 1;
    localparam int IDX_W       = TREE_LEVELS;
    localparam int LVL_W       = $clog2(TREE_LEVELS);
    localparam int SIZE_W      = 21;
    localparam logic [SIZE_W-1:0] TOTAL_RESET = SIZE_W'(1024);

    typedef enum logic [1:0] {
        TAG_FREE    = 2'd0,
        TAG_DIVIDED = 2'd1,
        TAG_ALLOC   = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        RES_OK        = 3'd0,
        RES_TOO_LARGE = 3'd1,
        RES_NO_SPACE  = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_ZERO_SIZE = 3'd4
    } res_code_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
    } in_item_t;

    typedef struct packed {
        res_code_t         status;
        logic [IDX_W-1:0]  node_index;
        logic [SIZE_W-1:0] block_size;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_LEVEL,
        ST_ARD,
        ST_ACHK,
        ST_ANC_RD,
        ST_ANC_CHK,
        ST_AMARK,
        ST_ADIV,
        ST_FRD,
        ST_FCHK,
        ST_FWR,
        ST_BRD,
        ST_BCHK,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_LEVEL,
        DP_RD_NODE,
        DP_RD_ANC,
        DP_NEXT,
        DP_WR_ALLOC,
        DP_WR_DIV,
        DP_WR_FREE,
        DP_RD_BUDDY,
        DP_MERGE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        res_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_zero;
        logic too_large;
        logic is_free_op;
        logic level_go;
        logic node_last;
        logic node_end;
        logic tag_free;
        logic tag_alloc;
        logic req_match;
        logic anc_root;
    } dp_stat_t;

    // Level of a node: position of the leading one of index plus one
    function automatic logic [LVL_W-1:0] node_level(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] v;
        logic [LVL_W-1:0] lvl;
        v   = idx + IDX_W'(1);
        lvl = '0;
        for (int i = 1; i < IDX_W; i++)
        begin
            if (v[i])
            begin
                lvl = LVL_W'(i);
            end
        end
        return lvl;
    endfunction

endpackage

// ----- rtl/core/buddy_allocator.sv -----
// Binary buddy allocator top level: controller, datapath and checks.
// Reset clears control state, then a clearing pass marks each of the 2047 nodes free;
// no item is taken during it. One item at a time: zero-size items and too-large
// allocations go straight to the result; free scans the nodes for its block, then merges
// upward while buddies are free; allocate finds the level, then tries its nodes and reads
// the ancestors of each free one, all in turn on the single port of the node tag memory.
// The result register holds one item, so the next item is taken while it waits.
module buddy_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bud_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bud_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bud_pkg::out_item_t         out_item
);

    bud_pkg::dp_cmd_t  cmd;
    bud_pkg::dp_stat_t stat;

    bud_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    bud_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .stat        (stat),
        .out_item    (out_item)
    );

    // Failed items carry no node and no size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != bud_pkg::RES_OK
            |-> out_item.node_index == '0 && out_item.block_size == '0)
        else $error("failed result carries a node or size");

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without processing");

    // A new result appears only after an item was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a working item");

endmodule

// ----- rtl/core/bud_datapath.sv -----
// Datapath of the buddy allocator: node memories, walk pointers and result register.
module bud_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [bud_pkg::SIZE_W-1:0] cfg_wr_data,
    input  bud_pkg::in_item_t         in_item,
    input  bud_pkg::dp_cmd_t          cmd,
    output bud_pkg::dp_stat_t         stat,
    output bud_pkg::out_item_t        out_item
);

    bud_pkg::tag_t               tag_mem [bud_pkg::NODE_COUNT];
    logic [bud_pkg::SIZE_W-1:0]  req_mem [bud_pkg::NODE_COUNT];

    logic [bud_pkg::SIZE_W-1:0]  total_reg;
    logic [bud_pkg::IDX_W-1:0]   clr_reg;
    logic                        op_reg;
    logic [bud_pkg::SIZE_W-1:0]  req_reg;
    logic [bud_pkg::SIZE_W-1:0]  size_reg;
    logic [bud_pkg::LVL_W-1:0]   lvl_reg;
    logic [bud_pkg::IDX_W-1:0]   node_reg;
    logic [bud_pkg::IDX_W-1:0]   anc_reg;
    bud_pkg::tag_t               tag_rd_reg;
    logic [bud_pkg::SIZE_W-1:0]  req_rd_reg;
    bud_pkg::out_item_t          res_reg;

    logic [bud_pkg::IDX_W:0]     lvl_pow;
    logic [bud_pkg::IDX_W-1:0]   first_idx;
    logic [bud_pkg::IDX_W-1:0]   last_idx;
    logic [bud_pkg::IDX_W-1:0]   parent_idx;
    logic [bud_pkg::IDX_W-1:0]   buddy_idx;
    logic [bud_pkg::IDX_W-1:0]   mem_addr;
    logic                        tag_we;
    bud_pkg::tag_t               tag_wdata;
    logic                        req_we;

    // Level bounds and tree neighbours
    assign lvl_pow    = (bud_pkg::IDX_W+1)'(1) << lvl_reg;
    assign first_idx  = bud_pkg::IDX_W'(lvl_pow - (bud_pkg::IDX_W+1)'(1));
    assign last_idx   = bud_pkg::IDX_W'((lvl_pow << 1) - (bud_pkg::IDX_W+1)'(2));
    assign parent_idx = (anc_reg - bud_pkg::IDX_W'(1)) >> 1;
    assign buddy_idx  = anc_reg[0] ? anc_reg + bud_pkg::IDX_W'(1)
                                   : anc_reg - bud_pkg::IDX_W'(1);

    // Status towards the controller
    always_comb
    begin
        stat.clr_last   = (clr_reg == bud_pkg::IDX_W'(bud_pkg::NODE_COUNT - 1));
        stat.req_zero   = (req_reg == '0);
        stat.too_large  = (req_reg > total_reg);
        stat.is_free_op = (op_reg == bud_pkg::OP_FREE);
        stat.level_go   = (req_reg <= (size_reg >> 1))
                          && (lvl_reg < bud_pkg::LVL_W'(bud_pkg::TREE_LEVELS - 1));
        stat.node_last  = (node_reg == last_idx);
        stat.node_end   = (node_reg == bud_pkg::IDX_W'(bud_pkg::NODE_COUNT - 1));
        stat.tag_free   = (tag_rd_reg == bud_pkg::TAG_FREE);
        stat.tag_alloc  = (tag_rd_reg == bud_pkg::TAG_ALLOC);
        stat.req_match  = (req_rd_reg == req_reg);
        stat.anc_root   = (anc_reg == '0);
    end

    // Select memory address and write data
    always_comb
    begin
        mem_addr  = node_reg;
        tag_we    = 1'b0;
        tag_wdata = bud_pkg::TAG_FREE;
        req_we    = 1'b0;
        case (cmd.op)
            bud_pkg::DP_CLEAR:
            begin
                mem_addr = clr_reg;
                tag_we   = 1'b1;
            end
            bud_pkg::DP_RD_ANC:   mem_addr = parent_idx;
            bud_pkg::DP_WR_ALLOC:
            begin
                tag_we    = 1'b1;
                tag_wdata = bud_pkg::TAG_ALLOC;
                req_we    = 1'b1;
            end
            bud_pkg::DP_WR_DIV:
            begin
                mem_addr  = parent_idx;
                tag_we    = 1'b1;
                tag_wdata = bud_pkg::TAG_DIVIDED;
            end
            bud_pkg::DP_WR_FREE:  tag_we = 1'b1;
            bud_pkg::DP_RD_BUDDY: mem_addr = buddy_idx;
            bud_pkg::DP_MERGE:
            begin
                mem_addr = parent_idx;
                tag_we   = 1'b1;
            end
            default:              mem_addr = node_reg;
        endcase
    end

    // Node memories with registered read
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[mem_addr] <= tag_wdata;
        end
        if (req_we)
        begin
            req_mem[mem_addr] <= req_reg;
        end
        tag_rd_reg <= tag_mem[mem_addr];
        req_rd_reg <= req_mem[mem_addr];
    end

    // Hold configuration and clearing pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= bud_pkg::TOTAL_RESET;
            clr_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                total_reg <= cfg_wr_data;
            end
            if (cmd.op == bud_pkg::DP_CLEAR)
            begin
                clr_reg <= clr_reg + bud_pkg::IDX_W'(1);
            end
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bud_pkg::DP_LOAD:
            begin
                op_reg   <= in_item.opcode;
                req_reg  <= in_item.request_size;
                size_reg <= total_reg;
                lvl_reg  <= '0;
                node_reg <= '0;
            end
            bud_pkg::DP_LEVEL:
            begin
                if (stat.level_go)
                begin
                    size_reg <= size_reg >> 1;
                    lvl_reg  <= lvl_reg + bud_pkg::LVL_W'(1);
                end
                else
                begin
                    node_reg <= first_idx;
                end
            end
            bud_pkg::DP_RD_NODE:  anc_reg  <= node_reg;
            bud_pkg::DP_RD_ANC:   anc_reg  <= parent_idx;
            bud_pkg::DP_NEXT:     node_reg <= node_reg + bud_pkg::IDX_W'(1);
            bud_pkg::DP_WR_ALLOC: anc_reg  <= node_reg;
            bud_pkg::DP_WR_DIV:   anc_reg  <= parent_idx;
            bud_pkg::DP_WR_FREE:  anc_reg  <= node_reg;
            bud_pkg::DP_MERGE:    anc_reg  <= parent_idx;
            bud_pkg::DP_RESULT:
            begin
                res_reg.status <= cmd.code;
                if (cmd.code == bud_pkg::RES_OK)
                begin
                    res_reg.node_index <= node_reg;
                    res_reg.block_size <= total_reg >> bud_pkg::node_level(node_reg);
                end
                else
                begin
                    res_reg.node_index <= '0;
                    res_reg.block_size <= '0;
                end
            end
            default:              anc_reg <= anc_reg;
        endcase
    end

    assign out_item = res_reg;

endmodule

// ----- rtl/core/bud_ctrl.sv -----
// Controller state machine of the buddy allocator.
module bud_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  bud_pkg::dp_stat_t stat,
    output bud_pkg::dp_cmd_t  cmd,
    output logic              in_stall,
    output logic              out_valid
);

    bud_pkg::ctrl_state_t state_reg;
    bud_pkg::ctrl_state_t state_next;
    bud_pkg::res_code_t   code_reg;
    bud_pkg::res_code_t   code_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 emit_ok;

    assign emit_ok = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            bud_pkg::ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = bud_pkg::ST_IDLE;
                end
            end
            bud_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bud_pkg::ST_CHECK;
                end
            end
            bud_pkg::ST_CHECK:
            begin
                if (stat.req_zero)
                begin
                    code_next  = bud_pkg::RES_ZERO_SIZE;
                    state_next = bud_pkg::ST_EMIT;
                end
                else if (stat.is_free_op)
                begin
                    state_next = bud_pkg::ST_FRD;
                end
                else if (stat.too_large)
                begin
                    code_next  = bud_pkg::RES_TOO_LARGE;
                    state_next = bud_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = bud_pkg::ST_LEVEL;
                end
            end
            bud_pkg::ST_LEVEL:
            begin
                if (!stat.level_go)
                begin
                    state_next = bud_pkg::ST_ARD;
                end
            end
            bud_pkg::ST_ARD:    state_next = bud_pkg::ST_ACHK;
            bud_pkg::ST_ACHK:
            begin
                if (stat.tag_free)
                begin
                    state_next = stat.anc_root ? bud_pkg::ST_AMARK : bud_pkg::ST_ANC_RD;
                end
                else if (stat.node_last)
                begin
                    code_next  = bud_pkg::RES_NO_SPACE;
                    state_next = bud_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = bud_pkg::ST_ARD;
                end
            end
            bud_pkg::ST_ANC_RD: state_next = bud_pkg::ST_ANC_CHK;
            bud_pkg::ST_ANC_CHK:
            begin
                if (stat.tag_alloc)
                begin
                    if (stat.node_last)
                    begin
                        code_next  = bud_pkg::RES_NO_SPACE;
                        state_next = bud_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = bud_pkg::ST_ARD;
                    end
                end
                else
                begin
                    state_next = stat.anc_root ? bud_pkg::ST_AMARK : bud_pkg::ST_ANC_RD;
                end
            end
            bud_pkg::ST_AMARK:  state_next = bud_pkg::ST_ADIV;
            bud_pkg::ST_ADIV:
            begin
                if (stat.anc_root)
                begin
                    code_next  = bud_pkg::RES_OK;
                    state_next = bud_pkg::ST_EMIT;
                end
            end
            bud_pkg::ST_FRD:    state_next = bud_pkg::ST_FCHK;
            bud_pkg::ST_FCHK:
            begin
                if (stat.tag_alloc && stat.req_match)
                begin
                    state_next = bud_pkg::ST_FWR;
                end
                else if (stat.node_end)
                begin
                    code_next  = bud_pkg::RES_NOT_FOUND;
                    state_next = bud_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = bud_pkg::ST_FRD;
                end
            end
            bud_pkg::ST_FWR:    state_next = bud_pkg::ST_BRD;
            bud_pkg::ST_BRD:
            begin
                if (stat.anc_root)
                begin
                    code_next  = bud_pkg::RES_OK;
                    state_next = bud_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = bud_pkg::ST_BCHK;
                end
            end
            bud_pkg::ST_BCHK:
            begin
                if (stat.tag_free)
                begin
                    state_next = bud_pkg::ST_BRD;
                end
                else
                begin
                    code_next  = bud_pkg::RES_OK;
                    state_next = bud_pkg::ST_EMIT;
                end
            end
            bud_pkg::ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = bud_pkg::ST_IDLE;
                end
            end
            default:            state_next = bud_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd.op   = bud_pkg::DP_NOP;
        cmd.code = code_reg;
        case (state_reg)
            bud_pkg::ST_CLEAR:   cmd.op = bud_pkg::DP_CLEAR;
            bud_pkg::ST_IDLE:    cmd.op = in_valid ? bud_pkg::DP_LOAD : bud_pkg::DP_NOP;
            bud_pkg::ST_LEVEL:   cmd.op = bud_pkg::DP_LEVEL;
            bud_pkg::ST_ARD:     cmd.op = bud_pkg::DP_RD_NODE;
            bud_pkg::ST_ACHK:
            begin
                if (!stat.tag_free && !stat.node_last)
                begin
                    cmd.op = bud_pkg::DP_NEXT;
                end
            end
            bud_pkg::ST_ANC_RD:  cmd.op = bud_pkg::DP_RD_ANC;
            bud_pkg::ST_ANC_CHK:
            begin
                if (stat.tag_alloc && !stat.node_last)
                begin
                    cmd.op = bud_pkg::DP_NEXT;
                end
            end
            bud_pkg::ST_AMARK:   cmd.op = bud_pkg::DP_WR_ALLOC;
            bud_pkg::ST_ADIV:    cmd.op = stat.anc_root ? bud_pkg::DP_NOP : bud_pkg::DP_WR_DIV;
            bud_pkg::ST_FRD:     cmd.op = bud_pkg::DP_RD_NODE;
            bud_pkg::ST_FCHK:
            begin
                if (!(stat.tag_alloc && stat.req_match) && !stat.node_end)
                begin
                    cmd.op = bud_pkg::DP_NEXT;
                end
            end
            bud_pkg::ST_FWR:     cmd.op = bud_pkg::DP_WR_FREE;
            bud_pkg::ST_BRD:     cmd.op = stat.anc_root ? bud_pkg::DP_NOP : bud_pkg::DP_RD_BUDDY;
            bud_pkg::ST_BCHK:    cmd.op = stat.tag_free ? bud_pkg::DP_MERGE : bud_pkg::DP_NOP;
            bud_pkg::ST_EMIT:    cmd.op = emit_ok ? bud_pkg::DP_RESULT : bud_pkg::DP_NOP;
            default:             cmd.op = bud_pkg::DP_NOP;
        endcase
    end

    // Output valid: set on a new item, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == bud_pkg::ST_EMIT && emit_ok)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bud_pkg::ST_CLEAR;
            code_reg      <= bud_pkg::RES_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != bud_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- verif/tb_buddy_allocator.sv -----
// Self-checking testbench for the buddy allocator: predicted tree state and randomised traffic.
module tb_buddy_allocator;
    import bud_pkg::*;

    localparam int CYCLE_LIMIT = 30_000_000;

    // Tree predictor and store of awaited results
    class buddy_scoreboard;
        tag_t              node_tag [NODE_COUNT];
        logic [SIZE_W-1:0] node_req [NODE_COUNT];
        logic [SIZE_W-1:0] root_size;
        out_item_t         awaited [$];

        function new();
            foreach (node_tag[i])
            begin
                node_tag[i] = TAG_FREE;
                node_req[i] = '0;
            end
            root_size = TOTAL_RESET;
        endfunction

        function void set_root_size(logic [SIZE_W-1:0] v);
            root_size = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // True if any ancestor of a node is already taken
        function bit under_taken(int n);
            int a;
            a = n;
            while (a != 0)
            begin
                a = (a - 1) >> 1;
                if (node_tag[a] == TAG_ALLOC)
                    return 1;
            end
            return 0;
        endfunction

        function int depth_of(int n);
            int d;
            int v;
            d = 0;
            v = n + 1;
            while (v > 1)
            begin
                v = v >> 1;
                d++;
            end
            return d;
        endfunction

        function out_item_t take_block(logic [SIZE_W-1:0] req);
            out_item_t         r;
            logic [SIZE_W-1:0] blk;
            int                lvl;
            int                a;
            r   = '{status: RES_NO_SPACE, node_index: '0, block_size: '0};
            blk = root_size;
            lvl = 0;
            if (req > blk)
            begin
                r.status = RES_TOO_LARGE;
                return r;
            end
            while (req <= (blk >> 1) && lvl < TREE_LEVELS - 1)
            begin
                blk = blk >> 1;
                lvl++;
            end
            for (int n = (1 << lvl) - 1; n <= (1 << (lvl + 1)) - 2; n++)
            begin
                if (node_tag[n] == TAG_FREE && !under_taken(n))
                begin
                    node_tag[n] = TAG_ALLOC;
                    node_req[n] = req;
                    a = n;
                    while (a != 0)
                    begin
                        a = (a - 1) >> 1;
                        node_tag[a] = TAG_DIVIDED;
                    end
                    r.status     = RES_OK;
                    r.node_index = IDX_W'(n);
                    r.block_size = blk;
                    return r;
                end
            end
            return r;
        endfunction

        function out_item_t give_back(logic [SIZE_W-1:0] req);
            out_item_t r;
            int        hit;
            int        n;
            int        buddy;
            r   = '{status: RES_NOT_FOUND, node_index: '0, block_size: '0};
            hit = -1;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                if (hit < 0 && node_tag[i] == TAG_ALLOC && node_req[i] == req)
                    hit = i;
            end
            if (hit < 0)
                return r;
            node_tag[hit] = TAG_FREE;
            n = hit;
            // merge upward while both halves are free
            while (n != 0)
            begin
                buddy = (n % 2 == 1) ? n + 1 : n - 1;
                if (node_tag[n] == TAG_FREE && node_tag[buddy] == TAG_FREE)
                begin
                    n = (n - 1) >> 1;
                    node_tag[n] = TAG_FREE;
                end
                else
                    break;
            end
            r.status     = RES_OK;
            r.node_index = IDX_W'(hit);
            r.block_size = root_size >> depth_of(hit);
            return r;
        endfunction

        // Note an accepted request and queue its awaited result
        function void note_request(in_item_t it);
            out_item_t r;
            if (it.request_size == '0)
                r = '{status: RES_ZERO_SIZE, node_index: '0, block_size: '0};
            else if (it.opcode == OP_ALLOC)
                r = take_block(it.request_size);
            else
                r = give_back(it.request_size);
            awaited.push_back(r);
        endfunction

        // Compare a result with the oldest awaited one; empty string when it matches
        function string check_result(out_item_t got);
            out_item_t e;
            string     msg;
            msg = "";
            if (awaited.size() == 0)
                return $sformatf(" unexpected result %p", got);
            e = awaited.pop_front();
            if (got.status != e.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.node_index != e.node_index)
                msg = {msg, $sformatf(" node %0d/%0d", got.node_index, e.node_index)};
            if (got.block_size != e.block_size)
                msg = {msg, $sformatf(" size %0d/%0d", got.block_size, e.block_size)};
            return msg;
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_item;

    buddy_scoreboard   sb;
    int                errors;
    int                cycles;
    bit                quiet;
    logic [SIZE_W-1:0] root_now;
    logic [SIZE_W-1:0] live_sizes [$];

    buddy_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report(string msg);
        $display("mismatch at cycle %0d:%s", cycles, msg);
        errors++;
    endtask

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stall, then take the next item
    initial
    begin
        int    n;
        string msg;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 11);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            msg = sb.check_result(out_item);
            if (msg != "")
                report(msg);
        end
    end

    task automatic send(logic op, logic [SIZE_W-1:0] sz);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{opcode: op, request_size: sz};
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request('{opcode: op, request_size: sz});
    endtask

    // Hold until every awaited result has been taken
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Drain, then write the root size while no item is in flight
    task automatic set_root(logic [SIZE_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_root_size(v);
        root_now = v;
    endtask

    // Mostly alloc/free pairs of live sizes, with some noise
    task automatic random_phase(int count);
        int                k;
        int                pick;
        logic [SIZE_W-1:0] top;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 10)
            begin
                k   = ($urandom_range(0, 7) == 0) ? 10 : $urandom_range(0, 5);
                top = root_now >> k;
                if (top == '0)
                    top = SIZE_W'(1);
                sz = SIZE_W'($urandom_range(1, top));
                live_sizes.push_back(sz);
                send(OP_ALLOC, sz);
            end
            else if (pick < 17 && live_sizes.size() > 0)
            begin
                k  = $urandom_range(0, live_sizes.size() - 1);
                sz = live_sizes[k];
                live_sizes.delete(k);
                send(OP_FREE, sz);
            end
            else if (pick == 17)
                send(1'($urandom_range(0, 1)), '0);
            else if (pick == 18)
                send(OP_ALLOC, SIZE_W'($urandom_range(0, 1048576)));
            else
                send(OP_FREE, SIZE_W'($urandom_range(1, 1048576)));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        sb          = new();
        errors      = 0;
        cycles      = 0;
        quiet       = 1'b0;
        root_now    = TOTAL_RESET;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero size, too large, exact fit, full tree, depth cap, miss
        set_root(SIZE_W'(1024));
        send(OP_ALLOC, SIZE_W'(0));
        send(OP_FREE, SIZE_W'(0));
        send(OP_ALLOC, SIZE_W'(1025));
        send(OP_ALLOC, SIZE_W'(1024));
        send(OP_ALLOC, SIZE_W'(1));
        send(OP_FREE, SIZE_W'(1024));
        send(OP_FREE, SIZE_W'(7));
        send(OP_ALLOC, SIZE_W'(1));
        send(OP_ALLOC, SIZE_W'(512));
        send(OP_ALLOC, SIZE_W'(300));
        send(OP_FREE, SIZE_W'(1));
        send(OP_FREE, SIZE_W'(512));
        send(OP_ALLOC, SIZE_W'(1048576));
        set_root(SIZE_W'(1048576));
        send(OP_ALLOC, SIZE_W'(1048576));
        send(OP_ALLOC, SIZE_W'(1));
        send(OP_FREE, SIZE_W'(1048576));
        send(OP_FREE, SIZE_W'(1));
        set_root(SIZE_W'(1));
        send(OP_ALLOC, SIZE_W'(1));
        send(OP_ALLOC, SIZE_W'(2));
        send(OP_FREE, SIZE_W'(1));

        // Random phases over several root sizes
        live_sizes.delete();
        set_root(SIZE_W'(1024));
        random_phase(35);
        live_sizes.delete();
        set_root(SIZE_W'(1048576));
        random_phase(30);
        live_sizes.delete();
        set_root(SIZE_W'(100));
        random_phase(20);
        live_sizes.delete();
        set_root(SIZE_W'(1));
        random_phase(8);
        live_sizes.delete();
        set_root(SIZE_W'($urandom_range(1, 1048576)));
        random_phase(25);

        // Let the last results drain
        in_valid <= 1'b0;
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/bud_pkg.sv
rtl/core/bud_datapath.sv
rtl/core/bud_ctrl.sv
rtl/core/buddy_allocator.sv
verif/tb_buddy_allocator.sv
